/* src/ttmg_pkg.sv */
`default_nettype none
package ttmg_pkg;

	localparam int TapsDefault = 3;
	localparam logic [31:0] TapWindowMs = 32'd1200;

	localparam logic [2:0] EV_MOVE  = 3'd0;
	localparam logic [2:0] EV_LDOWN = 3'd1;
	localparam logic [2:0] EV_LUP   = 3'd2;
	localparam logic [2:0] EV_RUP   = 3'd3;
	localparam logic [2:0] EV_KDOWN = 3'd4;
	localparam logic [2:0] EV_KUP   = 3'd5;
	localparam logic [2:0] EV_KBD   = 3'd6;

	localparam logic [2:0] REG_OVERLAY = 3'd0;
	localparam logic [2:0] REG_GAME_W  = 3'd1;
	localparam logic [2:0] REG_GAME_H  = 3'd2;
	localparam logic [2:0] REG_SCALE_W = 3'd3;
	localparam logic [2:0] REG_SCALE_H = 3'd4;
	localparam logic [2:0] REG_OFF_X   = 3'd5;
	localparam logic [2:0] REG_OFF_Y   = 3'd6;
	localparam logic [2:0] REG_LONG    = 3'd7;

	typedef struct packed {
		logic        pressed;
		logic        held;
		logic        released;
		logic [9:0]  touch_x;
		logic [9:0]  touch_y;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [9:0] out_x;
		logic [9:0] out_y;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic        overlay_mode;
		logic [10:0] game_width;
		logic [10:0] game_height;
		logic [9:0]  scaled_width;
		logic [9:0]  scaled_height;
		logic [9:0]  frame_offset_x;
		logic [8:0]  frame_offset_y;
		logic [15:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic       map_start;
		logic [9:0] map_x;
		logic [9:0] map_y;
	} map_cmd_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [9:0] gx;
		logic [9:0] gy;
	} map_sts_t;

endpackage
`default_nettype wire

/* src/ttmg_map.sv */
`default_nettype none
module ttmg_map (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ttmg_pkg::cfg_t     cfg,
	input  wire ttmg_pkg::map_cmd_t cmd,
	output ttmg_pkg::map_sts_t      sts
);
	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_MUL  = 4'b0010,
		M_DIV  = 4'b0100,
		M_FIN  = 4'b1000
	} mstate_t;

	mstate_t     state_q;
	logic        axis_q;
	logic [4:0]  cnt_q;
	logic [20:0] num_q;
	logic [20:0] quo_q;
	logic [10:0] rem_q;
	logic [10:0] ry_q;
	logic        negx_q, negy_q;
	logic [9:0]  gx_q, gy_q;
	logic [9:0]  tx_q, ty_q;

	logic        scale;
	logic [10:0] dx, dy;
	logic [11:0] rem_sh;
	logic [9:0]  divisor;
	logic [10:0] gdim;

	assign scale = (cfg.scaled_width != 10'd0) && (cfg.scaled_height != 10'd0);
	assign dx = {1'b0, tx_q} - {1'b0, cfg.frame_offset_x};
	assign dy = {1'b0, ty_q} - {2'b0, cfg.frame_offset_y};
	assign divisor = axis_q ? cfg.scaled_height : cfg.scaled_width;
	assign gdim = axis_q ? cfg.game_height : cfg.game_width;
	assign rem_sh = {rem_q, num_q[20]};

	function automatic logic [9:0] clampv(input logic neg, input logic [20:0] v,
			input logic [10:0] lim);
		logic [10:0] top;
		begin
			top = (lim > 11'd1024) ? 11'd1023 : lim - 11'd1;
			if (lim == 11'd0 || neg) clampv = 10'd0;
			else if (v > {10'd0, top}) clampv = top[9:0];
			else clampv = v[9:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
		end else begin
			case (state_q)
				M_IDLE: if (cmd.map_start) state_q <= M_MUL;
				M_MUL: begin
					if (cfg.overlay_mode || !scale) state_q <= M_FIN;
					else state_q <= M_DIV;
				end
				M_DIV: if (cnt_q == 5'd21 && axis_q) state_q <= M_FIN;
				M_FIN: state_q <= M_IDLE;
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				tx_q <= cmd.map_x;
				ty_q <= cmd.map_y;
				axis_q <= 1'b0;
				cnt_q <= 5'd0;
			end
			M_MUL: begin
				negx_q <= dx[10];
				negy_q <= dy[10];
				ry_q <= dy;
				num_q <= {10'd0, dx[10] ? 11'd0 : dx} * {10'd0, cfg.game_width};
				rem_q <= 11'd0;
				if (cfg.overlay_mode) begin
					gx_q <= (tx_q >= 10'd800) ? 10'd799 : tx_q;
					gy_q <= (ty_q >= 10'd480) ? 10'd479 : ty_q;
				end else if (!scale) begin
					gx_q <= clampv(dx[10], {11'd0, dx[9:0]}, cfg.game_width);
					gy_q <= clampv(dy[10], {11'd0, dy[9:0]}, cfg.game_height);
				end
			end
			M_DIV: begin
				if (cnt_q == 5'd21) begin
					if (!axis_q) begin
						gx_q <= clampv(negx_q, quo_q, gdim);
						num_q <= {10'd0, ry_q[10] ? 11'd0 : ry_q} * {10'd0, cfg.game_height};
						rem_q <= 11'd0;
						cnt_q <= 5'd0;
						axis_q <= 1'b1;
					end else begin
						gy_q <= clampv(negy_q, quo_q, gdim);
					end
				end else begin
					cnt_q <= cnt_q + 5'd1;
					if (rem_sh >= {2'b0, divisor}) begin
						rem_q <= 11'(rem_sh - {2'b0, divisor});
						quo_q <= {quo_q[19:0], 1'b1};
					end else begin
						rem_q <= rem_sh[10:0];
						quo_q <= {quo_q[19:0], 1'b0};
					end
					num_q <= {num_q[19:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign sts.busy = (state_q != M_IDLE);
	assign sts.done = (state_q == M_FIN);
	assign sts.gx = gx_q;
	assign sts.gy = gy_q;
endmodule
`default_nettype wire

/* src/ttmg_ctrl.sv */
`default_nettype none
module ttmg_ctrl #(
	parameter int TAPS = ttmg_pkg::TapsDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ttmg_pkg::cfg_t     cfg,
	input  wire ttmg_pkg::in_item_t in_item,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output ttmg_pkg::out_item_t     out_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ttmg_pkg::map_cmd_t      cmd,
	input  wire ttmg_pkg::map_sts_t sts
);
	localparam int CW = $clog2(TAPS + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_TAP   = 6'b000010,
		S_START = 6'b000100,
		S_WAIT  = 6'b001000,
		S_OUT1  = 6'b010000,
		S_OUT2  = 6'b100000
	} state_t;

	state_t state_q;
	logic [1:0]  phase_q;
	logic        down_sent_q;
	logic [9:0]  held_x_q, held_y_q;
	logic [31:0] start_q;
	logic [CW-1:0] cnt_q [2];
	logic [31:0] times_q [2][TAPS];
	ttmg_pkg::in_item_t it_q;
	logic [2:0] k1_q, k2_q;
	logic       two_q, map1_q, map2_q, c_q;
	logic [9:0] mx_q, my_q;
	ttmg_pkg::out_item_t ob_q;
	logic       ob_v_q;
	logic       act_started_q;

	logic        in_bl, in_br;
	logic [CW-1:0] n, n2;
	logic [31:0] t [TAPS];
	logic [31:0] t2 [TAPS];
	logic        fire;
	logic [31:0] dur;
	logic        ob_load;

	assign in_bl = (it_q.touch_y > 10'd400) && (it_q.touch_x < 10'd80);
	assign in_br = (it_q.touch_y > 10'd400) && (it_q.touch_x > 10'd720);
	assign dur = it_q.now_ms - start_q;

	always_comb begin
		n = cnt_q[c_q];
		if (n > CW'(TAPS)) n = CW'(TAPS);
		for (int i = 0; i < TAPS; i++) t[i] = times_q[c_q][i];
		for (int s = 0; s < TAPS; s++) begin
			if (n > '0 && (it_q.now_ms - t[0]) > ttmg_pkg::TapWindowMs) begin
				for (int i = 0; i + 1 < TAPS; i++) t[i] = t[i + 1];
				n = n - 1'b1;
			end
		end
		for (int i = 0; i < TAPS; i++) t2[i] = t[i];
		n2 = n;
		if (n < CW'(TAPS)) begin
			for (int i = 0; i < TAPS; i++)
				if (CW'(i) == n) t2[i] = it_q.now_ms;
			n2 = n + 1'b1;
		end else begin
			for (int i = 0; i + 1 < TAPS; i++) t2[i] = t[i + 1];
			t2[TAPS-1] = it_q.now_ms;
		end
		fire = (n2 == CW'(TAPS)) && ((it_q.now_ms - t2[0]) <= ttmg_pkg::TapWindowMs);
	end

	assign in_ready = (state_q == S_IDLE);
	assign ob_load = ((state_q == S_OUT1) || (state_q == S_OUT2)) && (!ob_v_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 2'd0;
			down_sent_q <= 1'b0;
			held_x_q <= 10'd0;
			held_y_q <= 10'd0;
			start_q <= 32'd0;
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			for (int c = 0; c < 2; c++)
				for (int i = 0; i < TAPS; i++) times_q[c][i] <= 32'd0;
			ob_v_q <= 1'b0;
			c_q <= 1'b0;
		end else begin
			if (ob_load) ob_v_q <= 1'b1;
			else if (out_ready) ob_v_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_START;
				S_START: begin
					two_q <= 1'b0; map2_q <= 1'b0;
					if (phase_q == 2'd1) begin
						mx_q <= held_x_q; my_q <= held_y_q;
						if (!down_sent_q && it_q.held) begin
							down_sent_q <= 1'b1; phase_q <= 2'd2;
							k1_q <= ttmg_pkg::EV_LDOWN; map1_q <= 1'b1;
							state_q <= S_WAIT;
						end else begin
							map1_q <= 1'b0; state_q <= S_IDLE;
							if (it_q.released || !it_q.held) phase_q <= 2'd0;
						end
					end else if (phase_q == 2'd2) begin
						if (it_q.released || !it_q.held) begin
							phase_q <= 2'd0;
							mx_q <= held_x_q; my_q <= held_y_q;
							k1_q <= (dur >= {16'd0, cfg.long_press_ms}) ?
								ttmg_pkg::EV_RUP : ttmg_pkg::EV_LUP;
							map1_q <= 1'b1; state_q <= S_WAIT;
						end else if (it_q.touch_x != held_x_q || it_q.touch_y != held_y_q) begin
							held_x_q <= it_q.touch_x; held_y_q <= it_q.touch_y;
							mx_q <= it_q.touch_x; my_q <= it_q.touch_y;
							k1_q <= ttmg_pkg::EV_MOVE; map1_q <= 1'b1; state_q <= S_WAIT;
						end else begin
							map1_q <= 1'b0; state_q <= S_IDLE;
						end
					end else if (it_q.pressed || it_q.held) begin
						held_x_q <= it_q.touch_x; held_y_q <= it_q.touch_y;
						mx_q <= it_q.touch_x; my_q <= it_q.touch_y;
						start_q <= it_q.now_ms; phase_q <= 2'd1; down_sent_q <= 1'b0;
						c_q <= in_br;
						if (in_bl || in_br) begin
							map1_q <= 1'b0; state_q <= S_TAP;
						end else begin
							k1_q <= ttmg_pkg::EV_MOVE; map1_q <= 1'b1; state_q <= S_WAIT;
						end
					end else begin
						phase_q <= 2'd0; map1_q <= 1'b0; state_q <= S_IDLE;
					end
				end
				S_TAP: begin
					for (int i = 0; i < TAPS; i++) times_q[c_q][i] <= t2[i];
					cnt_q[c_q] <= fire ? '0 : n2;
					if (fire && c_q) begin
						k1_q <= ttmg_pkg::EV_KDOWN; k2_q <= ttmg_pkg::EV_KUP;
						two_q <= 1'b1; phase_q <= 2'd0;
					end else if (fire) begin
						k1_q <= ttmg_pkg::EV_KBD; k2_q <= ttmg_pkg::EV_MOVE;
						two_q <= 1'b1; map2_q <= 1'b1;
					end else begin
						k1_q <= ttmg_pkg::EV_MOVE; map1_q <= 1'b1;
					end
					state_q <= S_WAIT;
				end
				S_WAIT: if (!(map1_q || map2_q) || sts.done) state_q <= S_OUT1;
				S_OUT1: if (ob_load) begin
					ob_q.event_kind <= k1_q;
					ob_q.out_x <= map1_q ? sts.gx : 10'd0;
					ob_q.out_y <= map1_q ? sts.gy : 10'd0;
					ob_q.last_of_run <= !two_q;
					state_q <= two_q ? S_OUT2 : S_IDLE;
				end
				S_OUT2: if (ob_load) begin
					ob_q.event_kind <= k2_q;
					ob_q.out_x <= map2_q ? sts.gx : 10'd0;
					ob_q.out_y <= map2_q ? sts.gy : 10'd0;
					ob_q.last_of_run <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) it_q <= in_item;
	end

	assign cmd.map_start = (state_q == S_WAIT) && (map1_q || map2_q) && !sts.busy
		&& !sts.done && !act_started_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) act_started_q <= 1'b0;
		else if (state_q != S_WAIT) act_started_q <= 1'b0;
		else if (cmd.map_start) act_started_q <= 1'b1;
	end
	assign cmd.map_x = mx_q;
	assign cmd.map_y = my_q;

	assign out_item = ob_q;
	assign out_valid = ob_v_q;
endmodule
`default_nettype wire

/* src/touch_to_mouse_gesture_engine.sv */
// Touch-to-mouse gesture engine: one touch sample per input transfer gives
// zero, one or two mouse or key events, the last marked by last_of_run. One
// sample is in flight at a time; a sample whose coordinate is scaled waits for
// the shared bit-serial divider, which scales x and then y. An unscaled or
// overlay coordinate is clamped without the divider, and a sample with no
// mapped coordinate skips the mapper. Configuration registers are to be
// written only while no sample is in flight; the user must keep to this, as
// the block itself does not enforce it.
`default_nettype none
module touch_to_mouse_gesture_engine #(
	parameter int TAPS_PER_GESTURE = ttmg_pkg::TapsDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ttmg_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ttmg_pkg::out_item_t     out_data,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_wdata
);
	ttmg_pkg::cfg_t     cfg_q;
	ttmg_pkg::map_cmd_t cmd;
	ttmg_pkg::map_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.overlay_mode <= 1'b0;
			cfg_q.game_width <= 11'd320;
			cfg_q.game_height <= 11'd200;
			cfg_q.scaled_width <= 10'd320;
			cfg_q.scaled_height <= 10'd200;
			cfg_q.frame_offset_x <= 10'd0;
			cfg_q.frame_offset_y <= 9'd0;
			cfg_q.long_press_ms <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				ttmg_pkg::REG_OVERLAY: cfg_q.overlay_mode <= cfg_wdata[0];
				ttmg_pkg::REG_GAME_W: cfg_q.game_width <= cfg_wdata[10:0];
				ttmg_pkg::REG_GAME_H: cfg_q.game_height <= cfg_wdata[10:0];
				ttmg_pkg::REG_SCALE_W: cfg_q.scaled_width <= cfg_wdata[9:0];
				ttmg_pkg::REG_SCALE_H: cfg_q.scaled_height <= cfg_wdata[9:0];
				ttmg_pkg::REG_OFF_X: cfg_q.frame_offset_x <= cfg_wdata[9:0];
				ttmg_pkg::REG_OFF_Y: cfg_q.frame_offset_y <= cfg_wdata[8:0];
				ttmg_pkg::REG_LONG: cfg_q.long_press_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ttmg_ctrl #(.TAPS(TAPS_PER_GESTURE)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_item(in_data), .in_valid(in_valid), .in_ready(in_ready),
		.out_item(out_data), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	ttmg_map u_map (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd(cmd), .sts(sts)
	);

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !in_ready)
		else $error("input taken while mapping");
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.event_kind != 3'd7)
		else $error("bad event kind");
`endif
endmodule
`default_nettype wire
